### rtl/fpmd_pkg.sv
// ----------------------------------------------------------------------------
// fpmd_pkg: shared types and constants of the fixed-point multiply/divide unit
// Operation codes, the classified request that the front end hands to the
// arithmetic back end, and the widths that the operand fields settle.
// ----------------------------------------------------------------------------
package fpmd_pkg;

  // operand and result widths
  localparam int unsigned OpW  = 32;
  localparam int unsigned ResW = 64;
  // numerator of the shared divider: a*b + addend stays below 2^63
  localparam int unsigned NumW = 63;

  // saturated magnitude for a zero divisor
  localparam logic [OpW-1:0] SatMag = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_MUL    = 2'd0,
    CMD_DIV    = 2'd1,
    CMD_MULDIV = 2'd2
  } fpmd_cmd_e;

  // classified request: every command becomes (mul_a*mul_b + addend) / den
  typedef struct packed {
    logic [OpW-1:0] mul_a;
    logic [OpW-1:0] mul_b;
    logic [OpW-1:0] addend;
    logic [OpW-1:0] den;
    logic           neg;
    logic           zd;
  } fpmd_item_t;

endpackage

### rtl/fixed_point_mul_div_unit_top.sv
// ----------------------------------------------------------------------------
// fixed_point_mul_div_unit_top: signed fixed-point multiply / divide unit
// Multiply, divide and multiply-divide with round-half-up on magnitudes.
// ----------------------------------------------------------------------------
// Accepts one request per clock and returns one result per clock unless the
// output stalls, which holds the whole back end. Each request goes through a
// two-entry queue, a 32x32 multiplier stage, an add stage and a 63-stage
// restoring divider (one quotient bit per stage), then the output register.
module fixed_point_mul_div_unit_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] op_a_i,
  input  logic signed [31:0] op_b_i,
  input  logic signed [31:0] op_c_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] result_o,
  output logic               zero_divisor_o
);
  import fpmd_pkg::*;

  fpmd_item_t cls_item, head_item;
  logic       q_full, q_empty, q_pop;

  fpmd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .cmd_i  (cmd_i),
    .op_a_i (op_a_i),
    .op_b_i (op_b_i),
    .op_c_i (op_c_i),
    .item_o (cls_item)
  );

  fpmd_queue #(.DEPTH(2)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (cls_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (head_item)
  );

  assign in_stall_o = q_full;

  fpmd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .item_i         (head_item),
    .pop_o          (q_pop),
    .result_o       (result_o),
    .zero_divisor_o (zero_divisor_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

endmodule

### rtl/fpmd_front.sv
// ----------------------------------------------------------------------------
// fpmd_front: request classifier
// Takes operand magnitudes and sign, and maps each command onto one
// multiply-add-divide form for the back end.
// ----------------------------------------------------------------------------
module fpmd_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic [1:0]          cmd_i,
  input  logic signed [31:0]  op_a_i,
  input  logic signed [31:0]  op_b_i,
  input  logic signed [31:0]  op_c_i,
  output fpmd_pkg::fpmd_item_t item_o
);
  import fpmd_pkg::*;

  localparam logic [OpW-1:0] One  = OpW'(1) << FRAC_BITS;
  localparam logic [OpW-1:0] Half = OpW'(1) << (FRAC_BITS - 1);

  logic [OpW-1:0] mag_a, mag_b, mag_c;
  logic           sgn_ab;

  // magnitudes; the most negative value maps to 2^31 exactly
  assign mag_a  = op_a_i[OpW-1] ? (~op_a_i + OpW'(1)) : op_a_i;
  assign mag_b  = op_b_i[OpW-1] ? (~op_b_i + OpW'(1)) : op_b_i;
  assign mag_c  = op_c_i[OpW-1] ? (~op_c_i + OpW'(1)) : op_c_i;
  assign sgn_ab = op_a_i[OpW-1] ^ op_b_i[OpW-1];

  // command decode
  always_comb begin
    item_o = '0;
    item_o.den = OpW'(1);
    unique case (cmd_i)
      CMD_MUL: begin
        item_o.mul_a  = mag_a;
        item_o.mul_b  = mag_b;
        item_o.addend = Half;
        item_o.den    = One;
        item_o.neg    = sgn_ab;
      end
      CMD_DIV: begin
        item_o.mul_a  = mag_a;
        item_o.mul_b  = One;
        item_o.addend = mag_b >> 1;
        item_o.zd     = (mag_b == '0);
        item_o.den    = item_o.zd ? OpW'(1) : mag_b;
        item_o.neg    = sgn_ab;
      end
      CMD_MULDIV: begin
        item_o.mul_a  = mag_a;
        item_o.mul_b  = mag_b;
        item_o.addend = mag_c >> 1;
        item_o.zd     = (mag_c == '0);
        item_o.den    = item_o.zd ? OpW'(1) : mag_c;
        item_o.neg    = sgn_ab ^ op_c_i[OpW-1];
      end
      default: begin
        // unused code: result 0, no flag
        item_o.den = OpW'(1);
      end
    endcase
  end

endmodule

### rtl/fpmd_queue.sv
// ----------------------------------------------------------------------------
// fpmd_queue: request queue between front and back end
// Small register FIFO with first-word fall-through read.
// ----------------------------------------------------------------------------
module fpmd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fpmd_pkg::fpmd_item_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output fpmd_pkg::fpmd_item_t pop_data_o
);
  import fpmd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  fpmd_item_t          mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue fill count out of range");

  // a pop on a non-empty queue with no push lowers the count by one
  a_cnt_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("queue count not decremented on pop");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count not incremented on push");

endmodule

### rtl/fpmd_back.sv
// ----------------------------------------------------------------------------
// fpmd_back: arithmetic back end
// Multiplier stage, add stage, pipelined restoring divider with one quotient
// bit per stage, then sign, saturation and the output register.
// ----------------------------------------------------------------------------
module fpmd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  fpmd_pkg::fpmd_item_t item_i,
  output logic                 pop_o,
  output logic signed [63:0]   result_o,
  output logic                 zero_divisor_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i
);
  import fpmd_pkg::*;

  typedef struct packed {
    logic [OpW-1:0]  rem;
    logic [NumW-1:0] num;
    logic [NumW-1:0] quo;
    logic [OpW-1:0]  den;
    logic            neg;
    logic            zd;
  } div_st_t;

  logic            adv;
  // multiply stage
  logic            mul_vld_q;
  logic [ResW-1:0] prod_q;
  logic [OpW-1:0]  add_q, den_q;
  logic            neg_q, zd_q;
  // divider stages
  logic            dv_vld_q [NumW+1];
  div_st_t         dv_q     [NumW+1];
  div_st_t         dv_d     [NumW];
  // output
  logic            out_vld_q;
  logic [ResW-1:0] res_q, res_d, mag;
  logic            zd_out_q;

  // whole pipeline moves when the output slot is free or being taken
  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= ResW'(item_i.mul_a) * ResW'(item_i.mul_b);
      add_q  <= item_i.addend;
      den_q  <= item_i.den;
      neg_q  <= item_i.neg;
      zd_q   <= item_i.zd;
    end
  end

  // add stage loads the divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].rem <= '0;
      dv_q[0].num <= NumW'(prod_q + ResW'(add_q));
      dv_q[0].quo <= '0;
      dv_q[0].den <= den_q;
      dv_q[0].neg <= neg_q;
      dv_q[0].zd  <= zd_q;
    end
  end

  // divider: one restoring step per stage
  for (genvar k = 0; k < NumW; k++) begin : g_div
    logic [OpW:0] trial;
    logic         ge;
    assign trial = {dv_q[k].rem, dv_q[k].num[NumW-1]};
    assign ge    = (trial >= {1'b0, dv_q[k].den});
    always_comb begin
      dv_d[k]     = dv_q[k];
      dv_d[k].rem = ge ? OpW'(trial - {1'b0, dv_q[k].den}) : OpW'(trial);
      dv_d[k].num = dv_q[k].num << 1;
      dv_d[k].quo = {dv_q[k].quo[NumW-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k+1] <= dv_d[k];
      end
    end
  end

  // valid bits along the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      for (int i = 0; i <= NumW; i++) dv_vld_q[i] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      mul_vld_q   <= !empty_i;
      dv_vld_q[0] <= mul_vld_q;
      for (int i = 0; i < NumW; i++) dv_vld_q[i+1] <= dv_vld_q[i];
      out_vld_q   <= dv_vld_q[NumW];
    end
  end

  // saturation and sign
  assign mag   = dv_q[NumW].zd ? ResW'(SatMag) : ResW'(dv_q[NumW].quo);
  assign res_d = dv_q[NumW].neg ? (ResW'(0) - mag) : mag;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q    <= res_d;
      zd_out_q <= dv_q[NumW].zd;
    end
  end

  assign result_o       = res_q;
  assign zero_divisor_o = zd_out_q;
  assign out_valid_o    = out_vld_q;

  // zero divisor always gives the saturated magnitude
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && zd_out_q) |->
      (res_q == ResW'(SatMag) || res_q == (ResW'(0) - ResW'(SatMag))))
    else $error("zero divisor without saturated result");

  // a held output keeps its value while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(res_q)))
    else $error("stalled result changed");

  // the final divider remainder stays below the divisor when the stage is in use
  a_quo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[NumW] |-> (dv_q[NumW].rem < dv_q[NumW].den))
    else $error("divider remainder not below divisor");

endmodule

### sim/fixed_point_mul_div_unit_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_mul_div_unit_top_test: self-checking bench of the mul/div unit
// Drives directed and random requests through the valid/stall handshake,
// predicts each signed rounded result and the zero-divisor flag, and
// compares every returned result with the oldest expectation in order.
// ----------------------------------------------------------------------------
module fixed_point_mul_div_unit_top_test;
  import fpmd_pkg::*;

  localparam int unsigned FracBits  = 16;
  localparam int          Latency   = 80;
  localparam int          WatchdogN = 5000;
  localparam int          NumRandom = 1100;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic               known;  // expected result typed in by hand
    logic signed [63:0] res;
    logic               zd;
  } req_row_t;

  typedef struct {
    logic signed [63:0] res;
    logic               zd;
  } fpmd_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         cmd_i;
  logic signed [31:0] op_a_i;
  logic signed [31:0] op_b_i;
  logic signed [31:0] op_c_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [63:0] result_o;
  logic               zero_divisor_o;

  fpmd_res_t  pending_q[$];
  req_row_t   dir_rows[$];
  int         n_errors;
  int         idle_cycles;
  bit         hold_off;
  bit         stim_done;

  fixed_point_mul_div_unit_top #(.FRAC_BITS(FracBits)) dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // magnitude of a 32-bit signed operand, toggling the sign accumulator
  function automatic logic [63:0] op_mag(logic signed [31:0] v, ref logic neg);
    if (v[31]) begin
      neg = ~neg;
      return 64'h1_0000_0000 - {32'b0, v};
    end
    return {32'b0, v};
  endfunction

  // predicted result of one request
  function automatic fpmd_res_t predict_mul_div(logic [1:0] cmd, logic signed [31:0] a,
                                                logic signed [31:0] b,
                                                logic signed [31:0] c);
    fpmd_res_t  r;
    logic       neg;
    logic [63:0] ma, mb, mc, m;
    neg = 1'b0;
    r.zd = 1'b0;
    ma = op_mag(a, neg);
    mb = op_mag(b, neg);
    m  = '0;
    case (cmd)
      CMD_MUL: begin
        m = (ma * mb + (64'd1 << (FracBits - 1))) >> FracBits;
      end
      CMD_DIV: begin
        if (mb == 0) begin
          m = {32'b0, SatMag};
          r.zd = 1'b1;
        end else begin
          m = ((ma << FracBits) + (mb >> 1)) / mb;
        end
      end
      CMD_MULDIV: begin
        mc = op_mag(c, neg);
        if (mc == 0) begin
          m = {32'b0, SatMag};
          r.zd = 1'b1;
        end else begin
          m = (ma * mb + (mc >> 1)) / mc;
        end
      end
      default: begin
        neg = 1'b0;
      end
    endcase
    r.res = neg ? -$signed(m) : $signed(m);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic signed [63:0] got,
                                 logic signed [63:0] want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic add_row(logic [1:0] cmd, logic signed [31:0] a, logic signed [31:0] b,
                         logic signed [31:0] c, logic known = 0,
                         logic signed [63:0] res = 0, logic zd = 0);
    req_row_t r;
    r.cmd = cmd; r.a = a; r.b = b; r.c = c; r.known = known; r.res = res; r.zd = zd;
    dir_rows.push_back(r);
  endtask

  // one request: hold valid until accepted, queue the expectation
  task automatic send_request(req_row_t r);
    fpmd_res_t e;
    e = predict_mul_div(r.cmd, r.a, r.b, r.c);
    if (r.known) begin
      e.res = r.res;
      e.zd  = r.zd;
    end
    in_valid_i <= 1'b1;
    cmd_i  <= r.cmd;
    op_a_i <= r.a;
    op_b_i <= r.b;
    op_c_i <= r.c;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(e);
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 0;
      3: return $signed($urandom_range(0, 255)) - 128;
      4: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  // stimulus
  initial begin
    req_row_t r;
    int burst;
    bit hold_done;
    n_errors = 0;
    hold_off = 1'b0;
    hold_done = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_MUL;
    op_a_i = '0;
    op_b_i = '0;
    op_c_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: extremes, every command, zero divisors, unused code
    add_row(CMD_MUL, 32'sh0001_0000, 32'sh0001_0000, 0, 1, 64'sh1_0000, 0);
    add_row(CMD_MUL, 0, 32'sh7FFF_FFFF, 0, 1, 0, 0);
    add_row(CMD_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 64'sh4000_0000_0000, 0);
    add_row(CMD_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    add_row(CMD_MUL, 32'sh0000_8000, 1, 0, 1, 1, 0);
    add_row(CMD_MUL, -32'sh0000_8000, 1, -1, 1, -1, 0);
    add_row(CMD_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_row(CMD_DIV, 32'sh0001_0000, 0, 0, 1, 64'sh7FFF_FFFF, 1);
    add_row(CMD_DIV, -32'sh0001_0000, 0, -5, 1, -64'sh7FFF_FFFF, 1);
    add_row(CMD_DIV, 32'sh8000_0000, 0, 0, 1, -64'sh7FFF_FFFF, 1);
    add_row(CMD_DIV, 0, 0, 0, 1, 64'sh7FFF_FFFF, 1);
    add_row(CMD_DIV, 32'sh8000_0000, 1, 0);
    add_row(CMD_DIV, 32'sh7FFF_FFFF, -1, 32'sh8000_0000);
    add_row(CMD_DIV, 1, 32'sh8000_0000, 0);
    add_row(CMD_DIV, 32'sh0003_0000, 32'sh0002_0000, 0);
    add_row(CMD_MULDIV, 32'sh0001_0000, 1, 0, 1, 64'sh7FFF_FFFF, 1);
    add_row(CMD_MULDIV, -1, 1, 0, 1, -64'sh7FFF_FFFF, 1);
    add_row(CMD_MULDIV, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 64'sh4000_0000_0000_0000, 0);
    add_row(CMD_MULDIV, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_row(CMD_MULDIV, 3, 1, 2, 1, 2, 0);
    add_row(CMD_MULDIV, -7, 5, -3);
    add_row(2'd3, 32'sh8000_0000, -1, -1, 1, 0, 0);
    add_row(2'd3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1, 0, 0);
    foreach (dir_rows[i]) send_request(dir_rows[i]);
    in_valid_i <= 1'b0;

    // pause until everything directed has come back
    while (pending_q.size() != 0) @(posedge clk_i);

    // random bursts; one long output hold-off part way through
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      if (n >= 300 && !hold_done) begin
        hold_off  = 1'b1;
        hold_done = 1'b1;
      end
      for (int k = 0; k < burst && n < NumRandom; k++, n++) begin
        r.cmd = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        r.a = rand_operand();
        r.b = rand_operand();
        r.c = rand_operand();
        r.known = 1'b0;
        send_request(r);
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int run;
    out_stall_i = 1'b0;
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end
      case ($urandom_range(0, 3))
        0: out_stall_i <= 1'b1;
        1: out_stall_i <= $urandom_range(0, 1);
        default: out_stall_i <= 1'b0;
      endcase
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    fpmd_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", result_o, 0);
      end else begin
        e = pending_q.pop_front();
        if (result_o !== e.res) report_mismatch("result", result_o, e.res);
        if (zero_divisor_o !== e.zd) report_mismatch("zero_divisor", zero_divisor_o, e.zd);
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // end of run
  initial begin
    @(posedge rst_ni);
    fork
      begin
        wait (stim_done && pending_q.size() == 0);
        repeat (Latency) @(posedge clk_i);
      end
      wait (idle_cycles >= WatchdogN);
    join_any
    if (idle_cycles >= WatchdogN) begin
      $display("watchdog expired with %0d results outstanding", pending_q.size());
      $display("RESULT: ERROR");
    end else if (n_errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
